[hw/rtl/assert_macros.svh]
// assertion macros shared by the rotator rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

[hw/rtl/mcr_pkg.sv]
// types and constants of the matrix rotator
// no dependencies; imported by every rotator module but mcr_ram
`default_nettype none

package mcr_pkg;

    localparam int MAX_DIM_DEF = 128;   // default matrix edge
    localparam int DIM_RESET   = 128;   // dimension after reset, before clamping
    localparam int IDX_W       = 7;     // logical row and column index width
    localparam int VAL_W       = 16;    // element width
    localparam int REQ_W       = 3;     // request code width
    localparam int CFG_IDX_W   = 2;     // config register index width
    localparam int CFG_DATA_W  = 8;     // config write data width
    localparam int Q_DEPTH     = 2;     // entries between front and back

    // request codes on the command port
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 3'd0,
        REQ_UP    = 3'd1,
        REQ_DOWN  = 3'd2,
        REQ_LEFT  = 3'd3,
        REQ_RIGHT = 3'd4,
        REQ_READ  = 3'd5
    } t_req;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS = 2'd0,
        REG_NUM_COLS = 2'd1
    } t_cfg_reg;

    // memory operation handed from front to back
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_READ_ZERO
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [VAL_W-1:0] data;
    } t_q_ctl;

endpackage

`default_nettype wire

[hw/rtl/matrix_cyclic_row_col_rotator.sv]
// top level of the matrix rotator: front end, operation queue, back end
// uses mcr_pkg, mcr_front, mcr_queue, mcr_back
//
// command channel: an item is taken at a rising edge with start high and busy
//   low; req_type selects write, rotate up/down/left/right or read, and the
//   row and column indexes are logical positions. rotations only move the
//   row or column offset, the data never moves
// result channel: each read gives one item, o_read_valid high for exactly one
//   cycle with o_read_value; the receiver cannot stall it and never needs to,
//   since results leave at the rate reads arrive
// config channel: i_cfg_valid / o_cfg_ready with index and data, ready always
//   high; writing num_rows clears the row offset, num_cols the column offset;
//   write only while no item is in flight
// timing: one item per cycle sustained, offsets and address are formed in
//   the accept cycle and the back does one memory access per cycle. a read's
//   result reaches the ports through the queue stage, then the registered
//   memory read. busy never rises: the back pops each entry in the cycle
//   after it is pushed, so the queue holds at most one
// reset: synchronous, active low; dimensions go to 128 (clamped to MAX_DIM),
//   offsets to zero, queue empties. the element memory is not cleared
`default_nettype none

module matrix_cyclic_row_col_rotator #(
    parameter int MAX_DIM = mcr_pkg::MAX_DIM_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // command channel
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [mcr_pkg::REQ_W-1:0]           i_req_type,
    input  wire logic [mcr_pkg::IDX_W-1:0]           i_row_index,
    input  wire logic [mcr_pkg::IDX_W-1:0]           i_col_index,
    input  wire logic signed [mcr_pkg::VAL_W-1:0]    i_write_value,
    // result channel
    output logic                                     o_read_valid,
    output logic signed [mcr_pkg::VAL_W-1:0]         o_read_value,
    // config channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [mcr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [mcr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import mcr_pkg::*;

    // physical address is {row, col}, each as wide as the largest index
    localparam int ADDR_W = 2 * $clog2(MAX_DIM);

    logic              accept;
    logic              cfg_wr;
    logic              q_push, q_pop, q_valid, q_full;
    t_q_ctl            front_ctl, q_ctl;
    logic [ADDR_W-1:0] front_addr, q_addr;

    // config is always taken; the contract keeps it away from live items
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // only a full queue holds off new commands
    assign busy   = q_full;
    assign accept = start && !busy;

    // classify the command, update offsets, form the memory address
    mcr_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req_type    (i_req_type),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .i_cfg_valid   (cfg_wr),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (q_push),
        .o_ctl         (front_ctl),
        .o_addr        (front_addr)
    );

    // decouples command acceptance from memory access
    mcr_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ctl   (front_ctl),
        .i_addr  (front_addr),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_ctl   (q_ctl),
        .o_addr  (q_addr)
    );

    // memory writes and reads, read results out
    mcr_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_ctl        (q_ctl),
        .i_addr       (q_addr),
        .o_pop        (q_pop),
        .o_read_valid (o_read_valid),
        .o_read_value (o_read_value)
    );

endmodule

`default_nettype wire

[hw/rtl/mcr_ram.sv]
// generic single port ram with registered read
// no dependencies
`default_nettype none

module mcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/mcr_front.sv]
// front end: takes commands, keeps dimensions and rotation offsets,
// maps logical positions to memory addresses; uses mcr_pkg
`default_nettype none
`include "assert_macros.svh"

module mcr_front #(
    parameter int MAX_DIM = mcr_pkg::MAX_DIM_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire logic [mcr_pkg::REQ_W-1:0]           i_req_type,
    input  wire logic [mcr_pkg::IDX_W-1:0]           i_row_index,
    input  wire logic [mcr_pkg::IDX_W-1:0]           i_col_index,
    input  wire logic signed [mcr_pkg::VAL_W-1:0]    i_write_value,
    input  wire logic                                i_cfg_valid,
    input  wire logic [mcr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [mcr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                     o_push,
    output mcr_pkg::t_q_ctl                          o_ctl,
    output logic      [2*$clog2(MAX_DIM)-1:0]        o_addr
);

    import mcr_pkg::*;

    localparam int OFF_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SUM_W = ((IDX_W > DIM_W) ? IDX_W : DIM_W) + 1;
    localparam int RESET_DIM = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;
    localparam logic [SUM_W-1:0] MAX_X = SUM_W'(MAX_DIM);
    localparam logic [SUM_W-1:0] ONE_X = SUM_W'(1);

    // a + b wrapped at n, with a and b below n
    function automatic logic [OFF_W-1:0] f_wrap(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b,
        input logic [SUM_W-1:0] n
    );
        logic [SUM_W-1:0] s;
        s = a + b;
        if (s >= n) begin
            s = s - n;
        end
        return s[OFF_W-1:0];
    endfunction

    // zero reads as one, above the maximum reads as the maximum
    function automatic logic [DIM_W-1:0] f_clamp(input logic [CFG_DATA_W-1:0] d);
        logic [SUM_W-1:0] dx;
        dx = SUM_W'(d);
        if (dx == '0) begin
            dx = ONE_X;
        end else if (dx > MAX_X) begin
            dx = MAX_X;
        end
        return dx[DIM_W-1:0];
    endfunction

    logic [DIM_W-1:0] r_rows, n_rows;
    logic [DIM_W-1:0] r_cols, n_cols;
    logic [OFF_W-1:0] r_row_off, n_row_off;
    logic [OFF_W-1:0] r_col_off, n_col_off;

    logic [SUM_W-1:0] rows_x, cols_x, roff_x, coff_x, ridx_x, cidx_x;
    logic             in_range;
    logic [OFF_W-1:0] phys_row, phys_col;

    assign rows_x = SUM_W'(r_rows);
    assign cols_x = SUM_W'(r_cols);
    assign roff_x = SUM_W'(r_row_off);
    assign coff_x = SUM_W'(r_col_off);
    assign ridx_x = SUM_W'(i_row_index);
    assign cidx_x = SUM_W'(i_col_index);

    assign in_range = (ridx_x < rows_x) && (cidx_x < cols_x);
    assign phys_row = f_wrap(ridx_x, roff_x, rows_x);
    assign phys_col = f_wrap(cidx_x, coff_x, cols_x);
    assign o_addr   = {phys_row, phys_col};

    always_comb begin
        n_rows    = r_rows;
        n_cols    = r_cols;
        n_row_off = r_row_off;
        n_col_off = r_col_off;
        o_push    = 1'b0;
        o_ctl.op  = OP_WRITE;
        o_ctl.data = i_write_value;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NUM_ROWS: begin
                    n_rows    = f_clamp(i_cfg_data);
                    n_row_off = '0;
                end
                REG_NUM_COLS: begin
                    n_cols    = f_clamp(i_cfg_data);
                    n_col_off = '0;
                end
                default: ;
            endcase
        end

        if (i_accept) begin
            unique case (i_req_type)
                REQ_WRITE: begin
                    o_push   = in_range;
                    o_ctl.op = OP_WRITE;
                end
                REQ_UP:    n_row_off = f_wrap(roff_x, ONE_X, rows_x);
                REQ_DOWN:  n_row_off = f_wrap(roff_x, rows_x - ONE_X, rows_x);
                REQ_LEFT:  n_col_off = f_wrap(coff_x, ONE_X, cols_x);
                REQ_RIGHT: n_col_off = f_wrap(coff_x, cols_x - ONE_X, cols_x);
                REQ_READ: begin
                    o_push   = 1'b1;
                    o_ctl.op = in_range ? OP_READ : OP_READ_ZERO;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= DIM_W'(RESET_DIM);
            r_cols    <= DIM_W'(RESET_DIM);
            r_row_off <= '0;
            r_col_off <= '0;
        end else begin
            r_rows    <= n_rows;
            r_cols    <= n_cols;
            r_row_off <= n_row_off;
            r_col_off <= n_col_off;
        end
    end

    `ASSERT_CLK(a_row_off_bound, i_clk, i_rst_n, roff_x < rows_x, "row offset not below rows")
    `ASSERT_CLK(a_col_off_bound, i_clk, i_rst_n, coff_x < cols_x, "col offset not below cols")

endmodule

`default_nettype wire

[hw/rtl/mcr_queue.sv]
// short fifo of memory operations between front and back
// uses mcr_pkg
`default_nettype none
`include "assert_macros.svh"

module mcr_queue #(
    parameter int ADDR_W = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mcr_pkg::t_q_ctl   i_ctl,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic                   o_full,
    output mcr_pkg::t_q_ctl        o_ctl,
    output logic      [ADDR_W-1:0] o_addr
);

    import mcr_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_q_ctl            r_ctl  [Q_DEPTH];
    logic [ADDR_W-1:0] r_addr [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_ctl   = r_ctl[r_rd_ptr];
    assign o_addr  = r_addr[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? f_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? f_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr_ptr]  <= i_ctl;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

    `ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `ASSERT_NEVER(a_q_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

`default_nettype wire

[hw/rtl/mcr_back.sv]
// back end: drains the queue into the element memory and returns reads
// uses mcr_pkg and mcr_ram
`default_nettype none
`include "assert_macros.svh"

module mcr_back #(
    parameter int ADDR_W = 14
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_q_valid,
    input  wire mcr_pkg::t_q_ctl                  i_ctl,
    input  wire logic [ADDR_W-1:0]                i_addr,
    output logic                                  o_pop,
    output logic                                  o_read_valid,
    output logic signed [mcr_pkg::VAL_W-1:0]      o_read_value
);

    import mcr_pkg::*;

    logic             pop_wr, pop_rd, ram_re;
    logic [VAL_W-1:0] ram_q;
    logic             r_rd_pend, n_rd_pend;
    logic             r_rd_zero, n_rd_zero;

    // one operation per cycle, so the queue drains as fast as it fills
    assign o_pop  = i_q_valid;
    assign pop_wr = o_pop && (i_ctl.op == OP_WRITE);
    assign pop_rd = o_pop && ((i_ctl.op == OP_READ) || (i_ctl.op == OP_READ_ZERO));
    assign ram_re = o_pop && (i_ctl.op == OP_READ);

    assign n_rd_pend = pop_rd;
    assign n_rd_zero = (i_ctl.op == OP_READ_ZERO);

    mcr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (1 << ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (pop_wr),
        .i_re    (ram_re),
        .i_addr  (i_addr),
        .i_wdata (i_ctl.data),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_rd) begin
            r_rd_zero <= n_rd_zero;
        end
    end

    assign o_read_valid = r_rd_pend;
    assign o_read_value = r_rd_zero ? '0 : ram_q;

    `ASSERT_CLK(a_result_from_read, i_clk, i_rst_n, o_read_valid |-> $past(pop_rd), "result without read")
    `ASSERT_CLK(a_read_gives_result, i_clk, i_rst_n, pop_rd |=> o_read_valid, "read lost")

endmodule

`default_nettype wire
